FILE: src/pbt_pkg.sv
// Package for the port binding table: field widths, operation and status codes,
// payload structs and internal control structs. No dependencies.

package pbt_pkg;

    localparam int MODE_W      = 2;
    localparam int SOCKET_ID_W = 4;
    localparam int PORT_W      = 16;
    localparam int IP_W        = 32;
    localparam int STATUS_W    = 3;
    localparam int MAX_SLOTS   = 2 ** SOCKET_ID_W;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [MODE_W-1:0] MODE_BIND     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_AUTOBIND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RELEASE  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_LOOKUP   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 3'd1;
    localparam logic [STATUS_W-1:0] ST_IN_USE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_PORT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISS    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_EPH_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EPH_HIGH = 1'b1;

    localparam logic [PORT_W-1:0] EPH_LOW_RESET  = 16'd49152;
    localparam logic [PORT_W-1:0] EPH_HIGH_RESET = 16'd65535;

    typedef struct packed {
        logic [MODE_W-1:0]      mode;
        logic [SOCKET_ID_W-1:0] socket_id;
        logic [PORT_W-1:0]      req_port;
        logic [IP_W-1:0]        req_ip;
    } pbt_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [PORT_W-1:0]      bound_port_out;
        logic [SOCKET_ID_W-1:0] found_socket;
        logic                   hit;
    } pbt_out_t;

    typedef struct packed {
        logic attach;
        logic rank_dec;
        logic detach;
    } pbt_tbl_cmd_t;

    typedef struct packed {
        logic port_hit;
        logic lookup_hit;
        logic bind_hit;
        logic rank_below;
        logic rank_above;
    } pbt_match_t;

endpackage

FILE: src/pbt_slot_table.sv
// Slot table of the port binding table: bound flags, port, IP and bind rank per slot.
// One read address; writes come from the sequencer. Depends on pbt_pkg.

module pbt_slot_table #(
    parameter int SLOTS  = 16,
    parameter int SLOT_W = 4,
    parameter int RANK_W = 5
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  pbt_pkg::pbt_tbl_cmd_t     cmd,
    input  logic [SLOT_W-1:0]         wr_sid,
    input  logic [pbt_pkg::PORT_W-1:0] wr_port,
    input  logic [pbt_pkg::IP_W-1:0]  wr_ip,
    input  logic [RANK_W-1:0]         wr_rank,
    input  logic [SLOT_W-1:0]         rd_idx,
    output logic                      rd_bound,
    output logic [pbt_pkg::PORT_W-1:0] rd_port,
    output logic [pbt_pkg::IP_W-1:0]  rd_ip,
    output logic [RANK_W-1:0]         rd_rank,
    output logic [SLOTS-1:0]          bound_vec
);

    logic [SLOTS-1:0]           bound_reg;
    logic [SLOTS-1:0]           bound_next;
    logic [pbt_pkg::PORT_W-1:0] port_reg [SLOTS];
    logic [pbt_pkg::IP_W-1:0]   ip_reg   [SLOTS];
    logic [RANK_W-1:0]          rank_reg [SLOTS];

    always_comb begin
        bound_next = bound_reg;
        if (cmd.attach) begin
            bound_next[wr_sid] = 1'b1;
        end
        if (cmd.detach) begin
            bound_next[wr_sid] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bound_reg <= '0;
        end else begin
            bound_reg <= bound_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.attach) begin
            port_reg[wr_sid] <= wr_port;
            ip_reg[wr_sid]   <= wr_ip;
        end
        if (cmd.attach) begin
            rank_reg[wr_sid] <= wr_rank;
        end else if (cmd.rank_dec) begin
            rank_reg[rd_idx] <= rank_reg[rd_idx] - RANK_W'(1);
        end
    end

    assign rd_bound  = bound_reg[rd_idx];
    assign rd_port   = port_reg[rd_idx];
    assign rd_ip     = ip_reg[rd_idx];
    assign rd_rank   = rank_reg[rd_idx];
    assign bound_vec = bound_reg;

endmodule

FILE: src/pbt_match.sv
// Shared compare unit: matches one table entry against the current key and rank.
// Used by every scan of the sequencer. Depends on pbt_pkg.

module pbt_match #(
    parameter int RANK_W = 5
) (
    input  logic                       ent_bound,
    input  logic [pbt_pkg::PORT_W-1:0] ent_port,
    input  logic [pbt_pkg::IP_W-1:0]   ent_ip,
    input  logic [RANK_W-1:0]          ent_rank,
    input  logic [pbt_pkg::PORT_W-1:0] key_port,
    input  logic [pbt_pkg::IP_W-1:0]   key_ip,
    input  logic [RANK_W-1:0]          rank_ref,
    output pbt_pkg::pbt_match_t        match
);

    logic ent_ip_any;
    logic key_ip_any;
    logic ip_eq;

    assign ent_ip_any = (ent_ip == '0);
    assign key_ip_any = (key_ip == '0);
    assign ip_eq      = (ent_ip == key_ip);

    always_comb begin
        match.port_hit   = ent_bound && (ent_port == key_port);
        match.lookup_hit = match.port_hit && (ent_ip_any || ip_eq);
        match.bind_hit   = match.port_hit && (ent_ip_any || key_ip_any || ip_eq);
        match.rank_below = (ent_rank < rank_ref);
        match.rank_above = (ent_rank > rank_ref);
    end

endmodule

FILE: src/pbt_seq.sv
// Sequencer of the port binding table: decodes an item, walks the slot table one
// slot per cycle through the shared compare unit and builds the result. Depends on pbt_pkg.

module pbt_seq #(
    parameter int SLOTS  = 16,
    parameter int SLOT_W = 4,
    parameter int RANK_W = 5
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  pbt_pkg::pbt_in_t           in_data,
    input  logic [pbt_pkg::PORT_W-1:0] eph_low,
    input  logic [pbt_pkg::PORT_W-1:0] eph_high,
    input  logic [SLOTS-1:0]           bound_vec,
    input  logic                       rd_bound,
    input  logic [pbt_pkg::PORT_W-1:0] rd_port,
    input  logic [RANK_W-1:0]          rd_rank,
    input  pbt_pkg::pbt_match_t        match,
    output logic [SLOT_W-1:0]          rd_idx,
    output pbt_pkg::pbt_tbl_cmd_t      cmd,
    output logic [SLOT_W-1:0]          wr_sid,
    output logic [pbt_pkg::PORT_W-1:0] wr_port,
    output logic [pbt_pkg::IP_W-1:0]   wr_ip,
    output logic [RANK_W-1:0]          wr_rank,
    output logic [pbt_pkg::PORT_W-1:0] key_port,
    output logic [pbt_pkg::IP_W-1:0]   key_ip,
    output logic [RANK_W-1:0]          rank_ref,
    input  logic                       out_free,
    output logic                       res_valid,
    output pbt_pkg::pbt_out_t          res_data
);

    localparam int ID_EXT_W = pbt_pkg::SOCKET_ID_W + 1;
    localparam int PORT_EXT_W = pbt_pkg::PORT_W + 1;
    localparam logic [ID_EXT_W-1:0] SLOT_LIMIT = ID_EXT_W'(SLOTS);
    localparam logic [SLOT_W-1:0]   LAST_IDX = SLOT_W'(SLOTS - 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_READ = 6'b000100,
        S_CAND = 6'b001000,
        S_DEC  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t                         state_reg, state_next;
    logic [pbt_pkg::MODE_W-1:0]     op_reg, op_next;
    logic [SLOT_W-1:0]              sid_reg, sid_next;
    logic [pbt_pkg::PORT_W-1:0]     key_port_reg, key_port_next;
    logic [pbt_pkg::IP_W-1:0]       key_ip_reg, key_ip_next;
    logic [SLOT_W-1:0]              idx_reg, idx_next;
    logic [RANK_W-1:0]              rank_ref_reg, rank_ref_next;
    logic                           hit_reg, hit_next;
    logic [SLOT_W-1:0]              found_reg, found_next;
    logic [PORT_EXT_W-1:0]          remain_reg, remain_next;
    logic [pbt_pkg::PORT_W-1:0]     next_eph_reg, next_eph_next;
    logic [RANK_W-1:0]              total_reg, total_next;
    pbt_pkg::pbt_out_t              res_reg, res_next;

    logic                           sid_ok;
    logic [SLOT_W-1:0]              sid_idx;
    logic                           last;
    logic [PORT_EXT_W-1:0]          cand_inc;
    logic [pbt_pkg::PORT_W-1:0]     cand_nxt;
    logic [pbt_pkg::PORT_W-1:0]     eph_start;
    logic [PORT_EXT_W-1:0]          eph_span;

    assign sid_ok  = ({1'b0, in_data.socket_id} < SLOT_LIMIT);
    assign sid_idx = in_data.socket_id[SLOT_W-1:0];
    assign last    = (idx_reg == LAST_IDX);

    assign cand_inc  = {1'b0, key_port_reg} + PORT_EXT_W'(1);
    assign cand_nxt  = (cand_inc > {1'b0, eph_high}) ? eph_low : cand_inc[pbt_pkg::PORT_W-1:0];
    assign eph_start = (next_eph_reg < eph_low || next_eph_reg > eph_high) ? eph_low
                                                                           : next_eph_reg;
    assign eph_span  = {1'b0, eph_high} - {1'b0, eph_low} + PORT_EXT_W'(1);

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        sid_next      = sid_reg;
        key_port_next = key_port_reg;
        key_ip_next   = key_ip_reg;
        idx_next      = idx_reg;
        rank_ref_next = rank_ref_reg;
        hit_next      = hit_reg;
        found_next    = found_reg;
        remain_next   = remain_reg;
        next_eph_next = next_eph_reg;
        total_next    = total_reg;
        res_next      = res_reg;
        cmd           = '0;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    op_next       = in_data.mode;
                    sid_next      = sid_idx;
                    key_port_next = in_data.req_port;
                    key_ip_next   = in_data.req_ip;
                    idx_next      = '0;
                    hit_next      = 1'b0;
                    found_next    = '0;
                    res_next      = '0;
                    res_next.status = pbt_pkg::ST_OK;
                    if (in_data.mode == pbt_pkg::MODE_LOOKUP) begin
                        state_next = S_SCAN;
                    end else if (!sid_ok) begin
                        res_next.status = pbt_pkg::ST_INVALID;
                        state_next      = S_DONE;
                    end else begin
                        case (in_data.mode)
                            pbt_pkg::MODE_BIND: begin
                                if (in_data.req_port == '0 || bound_vec[sid_idx]) begin
                                    res_next.status = pbt_pkg::ST_INVALID;
                                    state_next      = S_DONE;
                                end else begin
                                    state_next = S_SCAN;
                                end
                            end
                            pbt_pkg::MODE_AUTOBIND: begin
                                key_ip_next = '0;
                                if (bound_vec[sid_idx]) begin
                                    idx_next   = sid_idx;
                                    state_next = S_READ;
                                end else if (eph_low > eph_high) begin
                                    res_next.status = pbt_pkg::ST_NO_PORT;
                                    state_next      = S_DONE;
                                end else begin
                                    key_port_next = eph_start;
                                    remain_next   = eph_span;
                                    state_next    = S_CAND;
                                end
                            end
                            default: begin
                                if (bound_vec[sid_idx]) begin
                                    idx_next   = sid_idx;
                                    state_next = S_READ;
                                end else begin
                                    state_next = S_DONE;
                                end
                            end
                        endcase
                    end
                end
            end

            S_CAND: begin
                next_eph_next = cand_nxt;
                if (key_port_reg == '0) begin
                    if (remain_reg == PORT_EXT_W'(1)) begin
                        res_next.status = pbt_pkg::ST_NO_PORT;
                        state_next      = S_DONE;
                    end else begin
                        remain_next   = remain_reg - PORT_EXT_W'(1);
                        key_port_next = cand_nxt;
                    end
                end else begin
                    idx_next   = '0;
                    state_next = S_SCAN;
                end
            end

            S_SCAN: begin
                case (op_reg)
                    pbt_pkg::MODE_LOOKUP: begin
                        if (match.lookup_hit && (!hit_reg || match.rank_below)) begin
                            hit_next      = 1'b1;
                            found_next    = idx_reg;
                            rank_ref_next = rd_rank;
                        end
                        if (last) begin
                            res_next.hit          = hit_next;
                            res_next.status       = hit_next ? pbt_pkg::ST_OK : pbt_pkg::ST_MISS;
                            res_next.found_socket = hit_next
                                ? pbt_pkg::SOCKET_ID_W'(found_next) : '0;
                            state_next = S_DONE;
                        end else begin
                            idx_next = idx_reg + SLOT_W'(1);
                        end
                    end
                    pbt_pkg::MODE_BIND: begin
                        if (match.bind_hit) begin
                            res_next.status = pbt_pkg::ST_IN_USE;
                            state_next      = S_DONE;
                        end else if (last) begin
                            cmd.attach              = 1'b1;
                            total_next              = total_reg + RANK_W'(1);
                            res_next.bound_port_out = key_port_reg;
                            state_next              = S_DONE;
                        end else begin
                            idx_next = idx_reg + SLOT_W'(1);
                        end
                    end
                    pbt_pkg::MODE_AUTOBIND: begin
                        if (match.port_hit) begin
                            if (remain_reg == PORT_EXT_W'(1)) begin
                                res_next.status = pbt_pkg::ST_NO_PORT;
                                state_next      = S_DONE;
                            end else begin
                                remain_next   = remain_reg - PORT_EXT_W'(1);
                                key_port_next = cand_nxt;
                                state_next    = S_CAND;
                            end
                        end else if (last) begin
                            cmd.attach              = 1'b1;
                            total_next              = total_reg + RANK_W'(1);
                            res_next.bound_port_out = key_port_reg;
                            state_next              = S_DONE;
                        end else begin
                            idx_next = idx_reg + SLOT_W'(1);
                        end
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_READ: begin
                if (op_reg == pbt_pkg::MODE_AUTOBIND) begin
                    res_next.bound_port_out = rd_port;
                    state_next              = S_DONE;
                end else begin
                    rank_ref_next = rd_rank;
                    idx_next      = '0;
                    state_next    = S_DEC;
                end
            end

            S_DEC: begin
                if (rd_bound && match.rank_above) begin
                    cmd.rank_dec = 1'b1;
                end
                if (last) begin
                    cmd.detach = 1'b1;
                    total_next = total_reg - RANK_W'(1);
                    state_next = S_DONE;
                end else begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end

            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            total_reg    <= '0;
            next_eph_reg <= pbt_pkg::EPH_LOW_RESET;
        end else begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            next_eph_reg <= next_eph_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        sid_reg      <= sid_next;
        key_port_reg <= key_port_next;
        key_ip_reg   <= key_ip_next;
        idx_reg      <= idx_next;
        rank_ref_reg <= rank_ref_next;
        hit_reg      <= hit_next;
        found_reg    <= found_next;
        remain_reg   <= remain_next;
        res_reg      <= res_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res_data  = res_reg;
    assign rd_idx    = idx_reg;
    assign wr_sid    = sid_reg;
    assign wr_port   = key_port_reg;
    assign wr_ip     = key_ip_reg;
    assign wr_rank   = total_reg;
    assign key_port  = key_port_reg;
    assign key_ip    = key_ip_reg;
    assign rank_ref  = rank_ref_reg;

endmodule

FILE: src/port_bind_table_top.sv
// Top level of the port binding table: configuration registers, output register,
// and the sequencer, slot table and compare unit. Depends on pbt_pkg and src modules.
//
// Usage:
//   s_valid/s_ready/s_data carry one request item (bind, autobind, release, lookup).
//   m_valid/m_ready/m_data carry exactly one result item per request, in order.
//   cfg_we/cfg_index/cfg_wdata write ephemeral_low (index 0) or ephemeral_high (1);
//   write only while no request is in flight.
// Flow of a request (s_ready stays low until its result has left the sequencer):
//   lookup and a bind without conflict walk every slot once.
//   A bind conflict ends the walk at the first holder of the port.
//   release of a bound slot reads its slot, then walks all slots.
//   autobind of a bound slot reads its slot and returns its port. A bad slot
//   (outside lookup), an immediate reject or a release of an unbound slot go straight to the result.
//   autobind search: each candidate is checked by a walk up to its first holder
//   (all slots for a free port); port 0 is skipped; each port is tried at most once.
//   Each walk goes through the single compare unit, one slot per cycle.
// Reset clears all bindings and sets the autobind pointer to 49152.
// A result waiting on a stalled m_ready sits in the output register; a new
// request is still accepted, and its result is held until the register frees.

module port_bind_table_top #(
    parameter int SOCKET_SLOTS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  pbt_pkg::pbt_in_t                     s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output pbt_pkg::pbt_out_t                    m_data,
    input  logic                                 cfg_we,
    input  logic [pbt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pbt_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    localparam int SLOTS  = (SOCKET_SLOTS < pbt_pkg::MAX_SLOTS) ? SOCKET_SLOTS
                                                                : pbt_pkg::MAX_SLOTS;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RANK_W = $clog2(SLOTS + 1);

    logic [pbt_pkg::PORT_W-1:0] eph_low_reg, eph_low_next;
    logic [pbt_pkg::PORT_W-1:0] eph_high_reg, eph_high_next;
    logic                       m_valid_reg, m_valid_next;
    pbt_pkg::pbt_out_t          m_data_reg, m_data_next;

    logic                       out_free;
    logic                       res_valid;
    pbt_pkg::pbt_out_t          res_data;
    logic [SLOTS-1:0]           bound_vec;
    logic                       rd_bound;
    logic [pbt_pkg::PORT_W-1:0] rd_port;
    logic [pbt_pkg::IP_W-1:0]   rd_ip;
    logic [RANK_W-1:0]          rd_rank;
    logic [SLOT_W-1:0]          rd_idx;
    pbt_pkg::pbt_tbl_cmd_t      cmd;
    logic [SLOT_W-1:0]          wr_sid;
    logic [pbt_pkg::PORT_W-1:0] wr_port;
    logic [pbt_pkg::IP_W-1:0]   wr_ip;
    logic [RANK_W-1:0]          wr_rank;
    logic [pbt_pkg::PORT_W-1:0] key_port;
    logic [pbt_pkg::IP_W-1:0]   key_ip;
    logic [RANK_W-1:0]          rank_ref;
    pbt_pkg::pbt_match_t        match;

    always_comb begin
        eph_low_next  = eph_low_reg;
        eph_high_next = eph_high_reg;
        if (cfg_we) begin
            case (cfg_index)
                pbt_pkg::CFG_EPH_LOW: begin
                    eph_low_next = cfg_wdata[pbt_pkg::PORT_W-1:0];
                end
                pbt_pkg::CFG_EPH_HIGH: begin
                    eph_high_next = cfg_wdata[pbt_pkg::PORT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_valid && out_free) begin
            m_valid_next = 1'b1;
            m_data_next  = res_data;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eph_low_reg  <= pbt_pkg::EPH_LOW_RESET;
            eph_high_reg <= pbt_pkg::EPH_HIGH_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            eph_low_reg  <= eph_low_next;
            eph_high_reg <= eph_high_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    pbt_slot_table #(
        .SLOTS  (SLOTS),
        .SLOT_W (SLOT_W),
        .RANK_W (RANK_W)
    ) u_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .wr_sid    (wr_sid),
        .wr_port   (wr_port),
        .wr_ip     (wr_ip),
        .wr_rank   (wr_rank),
        .rd_idx    (rd_idx),
        .rd_bound  (rd_bound),
        .rd_port   (rd_port),
        .rd_ip     (rd_ip),
        .rd_rank   (rd_rank),
        .bound_vec (bound_vec)
    );

    pbt_match #(
        .RANK_W (RANK_W)
    ) u_match (
        .ent_bound (rd_bound),
        .ent_port  (rd_port),
        .ent_ip    (rd_ip),
        .ent_rank  (rd_rank),
        .key_port  (key_port),
        .key_ip    (key_ip),
        .rank_ref  (rank_ref),
        .match     (match)
    );

    pbt_seq #(
        .SLOTS  (SLOTS),
        .SLOT_W (SLOT_W),
        .RANK_W (RANK_W)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .eph_low   (eph_low_reg),
        .eph_high  (eph_high_reg),
        .bound_vec (bound_vec),
        .rd_bound  (rd_bound),
        .rd_port   (rd_port),
        .rd_rank   (rd_rank),
        .match     (match),
        .rd_idx    (rd_idx),
        .cmd       (cmd),
        .wr_sid    (wr_sid),
        .wr_port   (wr_port),
        .wr_ip     (wr_ip),
        .wr_rank   (wr_rank),
        .key_port  (key_port),
        .key_ip    (key_ip),
        .rank_ref  (rank_ref),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

endmodule
